@@ design/esm_pkg.sv @@
// esm_pkg: shared types, constants and the key sequence rom contents
// for the escape sequence matcher. no dependencies.
`default_nettype none

package esm_pkg;

   localparam int TABLE_ENTRIES = 36;
   localparam int ENTRY_W       = 6;
   localparam int ROM_POS_W     = 4;
   localparam int ROM_SEQ_BYTES = 8;
   localparam int LEN_W         = 4;
   localparam int ACT_W         = 5;
   localparam int CHAR_W        = 7;

   localparam logic [CHAR_W-1:0] QMARK_CHAR = 7'd63;
   localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [ACT_W-1:0] act;
      logic [7:0]       data;
   } rom_word_type;

   // sequence bytes, first byte in the top byte lane
   function automatic rom_word_type rom_lookup(input logic [ENTRY_W-1:0] entry,
                                               input logic [ROM_POS_W-1:0] pos);
      logic [LEN_W-1:0]           len;
      logic [ACT_W-1:0]           act;
      logic [8*ROM_SEQ_BYTES-1:0] seq;
      logic [8*ROM_SEQ_BYTES-1:0] shifted;
      rom_word_type               word;
      len = '0;
      act = '0;
      seq = '0;
      unique case (entry)
         6'd0:  begin len = 4'd1; act = 5'd17; seq = 64'h01_00_00_00_00_00_00_00; end
         6'd1:  begin len = 4'd1; act = 5'd6;  seq = 64'h03_00_00_00_00_00_00_00; end
         6'd2:  begin len = 4'd1; act = 5'd8;  seq = 64'h04_00_00_00_00_00_00_00; end
         6'd3:  begin len = 4'd1; act = 5'd18; seq = 64'h05_00_00_00_00_00_00_00; end
         6'd4:  begin len = 4'd1; act = 5'd0;  seq = 64'h08_00_00_00_00_00_00_00; end
         6'd5:  begin len = 4'd1; act = 5'd11; seq = 64'h09_00_00_00_00_00_00_00; end
         6'd6:  begin len = 4'd1; act = 5'd4;  seq = 64'h0A_00_00_00_00_00_00_00; end
         6'd7:  begin len = 4'd2; act = 5'd4;  seq = 64'h0D_00_00_00_00_00_00_00; end
         6'd8:  begin len = 4'd2; act = 5'd4;  seq = 64'h0D_0A_00_00_00_00_00_00; end
         6'd9:  begin len = 4'd1; act = 5'd7;  seq = 64'h1A_00_00_00_00_00_00_00; end
         6'd10: begin len = 4'd2; act = 5'd5;  seq = 64'h1B_0A_00_00_00_00_00_00; end
         6'd11: begin len = 4'd3; act = 5'd5;  seq = 64'h1B_0D_00_00_00_00_00_00; end
         6'd12: begin len = 4'd5; act = 5'd3;  seq = 64'h1B_1B_5B_33_7E_00_00_00; end
         6'd13: begin len = 4'd4; act = 5'd14; seq = 64'h1B_1B_5B_43_00_00_00_00; end
         6'd14: begin len = 4'd4; act = 5'd13; seq = 64'h1B_1B_5B_44_00_00_00_00; end
         6'd15: begin len = 4'd3; act = 5'd18; seq = 64'h1B_4F_46_00_00_00_00_00; end
         6'd16: begin len = 4'd3; act = 5'd17; seq = 64'h1B_4F_48_00_00_00_00_00; end
         6'd17: begin len = 4'd6; act = 5'd14; seq = 64'h1B_5B_31_3B_33_43_00_00; end
         6'd18: begin len = 4'd6; act = 5'd13; seq = 64'h1B_5B_31_3B_33_44_00_00; end
         6'd19: begin len = 4'd4; act = 5'd17; seq = 64'h1B_5B_31_7E_00_00_00_00; end
         6'd20: begin len = 4'd5; act = 5'd19; seq = 64'h1B_5B_32_34_7E_00_00_00; end
         6'd21: begin len = 4'd4; act = 5'd12; seq = 64'h1B_5B_32_7E_00_00_00_00; end
         6'd22: begin len = 4'd6; act = 5'd3;  seq = 64'h1B_5B_33_3B_33_7E_00_00; end
         6'd23: begin len = 4'd4; act = 5'd1;  seq = 64'h1B_5B_33_7E_00_00_00_00; end
         6'd24: begin len = 4'd4; act = 5'd18; seq = 64'h1B_5B_34_7E_00_00_00_00; end
         6'd25: begin len = 4'd4; act = 5'd17; seq = 64'h1B_5B_37_7E_00_00_00_00; end
         6'd26: begin len = 4'd4; act = 5'd18; seq = 64'h1B_5B_38_7E_00_00_00_00; end
         6'd27: begin len = 4'd3; act = 5'd9;  seq = 64'h1B_5B_41_00_00_00_00_00; end
         6'd28: begin len = 4'd3; act = 5'd10; seq = 64'h1B_5B_42_00_00_00_00_00; end
         6'd29: begin len = 4'd3; act = 5'd15; seq = 64'h1B_5B_43_00_00_00_00_00; end
         6'd30: begin len = 4'd3; act = 5'd16; seq = 64'h1B_5B_44_00_00_00_00_00; end
         6'd31: begin len = 4'd3; act = 5'd18; seq = 64'h1B_5B_46_00_00_00_00_00; end
         6'd32: begin len = 4'd3; act = 5'd17; seq = 64'h1B_5B_48_00_00_00_00_00; end
         6'd33: begin len = 4'd2; act = 5'd2;  seq = 64'h1B_7F_00_00_00_00_00_00; end
         6'd34: begin len = 4'd1; act = 5'd0;  seq = 64'h7F_00_00_00_00_00_00_00; end
         default: begin len = '0; act = '0; seq = '0; end
      endcase
      shifted   = seq << (8 * pos);
      word.len  = len;
      word.act  = act;
      // positions past the stored bytes read as the terminator
      word.data = (pos < ROM_POS_W'(ROM_SEQ_BYTES)) ? shifted[8*ROM_SEQ_BYTES-1 -: 8] : 8'd0;
      return word;
   endfunction

endpackage

`default_nettype wire

@@ design/escape_sequence_matcher.sv @@
// escape_sequence_matcher: one key byte in per item, action codes or literal bytes out.
// an item is loaded and scanned down the rom from the saved entry; a full match issues
// an action, a partial match waits for the next byte, a miss reads the literals back
// from pending memory; rsp_tready stalls hold output. one item is in work at a time.
// reset (synchronous, active high) clears the search to the last entry at position
// zero and empties the result register; pending byte memory is not cleared.
`default_nettype none

module escape_sequence_matcher #(
   parameter int MAX_SEQ_LEN = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [7:0] key_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // [6:0] payload, [7] zero
   output logic            rsp_tuser,  // [0] is_action
   output logic            rsp_tlast   // last_of_run
);

   localparam int POS_W = (MAX_SEQ_LEN > 2) ? $clog2(MAX_SEQ_LEN) : 1;
   localparam int CMP_W = esm_pkg::ROM_POS_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SCAN, S_ACT, S_RD, S_OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [esm_pkg::ENTRY_W-1:0]   scan_entry_ff, scan_entry_in;
   logic [esm_pkg::ENTRY_W-1:0]   cur_ff, cur_in;
   logic [esm_pkg::ENTRY_W-1:0]   chk_ff, chk_in;
   logic [esm_pkg::CHAR_W-1:0]    byte_ff, byte_in;
   logic [esm_pkg::ACT_W-1:0]     act_ff, act_in;
   logic [POS_W-1:0]              emit_idx_ff, emit_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_action_ff, rsp_action_in;
   logic [esm_pkg::CHAR_W-1:0]    rsp_payload_ff, rsp_payload_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [esm_pkg::CHAR_W-1:0]    pend_mem [MAX_SEQ_LEN];
   logic [esm_pkg::CHAR_W-1:0]    rd_q_ff;

   esm_pkg::rom_word_type         rom_q;
   logic                          accept;
   logic                          slot_free;
   logic [esm_pkg::CHAR_W-1:0]    key_char;
   logic [CMP_W-1:0]              pos_x, pos_p1, len_x;
   logic                          considered, byte_gt, byte_eq;
   logic                          hit_full, hit_partial, hit_miss;

   esm_seq_rom u_rom (
      .clock (clock),
      .entry (cur_ff),
      .pos   (esm_pkg::ROM_POS_W'(pos_ff)),
      .rom_q (rom_q)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign key_char   = req_tdata[7] ? esm_pkg::QMARK_CHAR : req_tdata[6:0];

   // compare of the buffered byte against the rom byte of the checked entry
   always_comb begin
      pos_x       = CMP_W'(pos_ff);
      pos_p1      = pos_x + CMP_W'(1);
      len_x       = CMP_W'(rom_q.len);
      considered  = (rom_q.len != '0) && (pos_x <= len_x);
      byte_gt     = {1'b0, byte_ff} > rom_q.data;
      byte_eq     = {1'b0, byte_ff} == rom_q.data;
      hit_full    = considered && byte_eq && (pos_p1 == len_x);
      hit_partial = considered && byte_eq && !hit_full && (pos_p1 < CMP_W'(MAX_SEQ_LEN));
      // stop on greater byte, full buffer, or table exhausted
      hit_miss    = (considered && (byte_gt || (byte_eq && !hit_full && !hit_partial)))
                    || (!(considered && (byte_gt || byte_eq)) && (chk_ff == '0));
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      scan_entry_in  = scan_entry_ff;
      cur_in         = cur_ff;
      chk_in         = chk_ff;
      byte_in        = byte_ff;
      act_in         = act_ff;
      emit_idx_in    = emit_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_action_in  = rsp_action_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in  = key_char;
               cur_in   = scan_entry_ff;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            chk_in   = cur_ff;
            cur_in   = cur_ff - esm_pkg::ENTRY_W'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            priority if (hit_full) begin
               act_in   = rom_q.act;
               state_in = S_ACT;
            end else if (hit_partial) begin
               pos_in        = pos_ff + POS_W'(1);
               scan_entry_in = chk_ff;
               state_in      = S_IDLE;
            end else if (hit_miss) begin
               emit_idx_in = '0;
               state_in    = S_RD;
            end else begin
               chk_in = cur_ff;
               cur_in = cur_ff - esm_pkg::ENTRY_W'(1);
            end
         end
         S_ACT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = 1'b1;
               rsp_payload_in = esm_pkg::CHAR_W'(act_ff);
               rsp_last_in    = 1'b1;
               pos_in         = '0;
               scan_entry_in  = esm_pkg::LAST_ENTRY;
               state_in       = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = 1'b0;
               rsp_payload_in = rd_q_ff;
               rsp_last_in    = (emit_idx_ff == pos_ff);
               if (emit_idx_ff == pos_ff) begin
                  pos_in        = '0;
                  scan_entry_in = esm_pkg::LAST_ENTRY;
                  state_in      = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + POS_W'(1);
                  state_in    = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         scan_entry_ff <= esm_pkg::LAST_ENTRY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         scan_entry_ff <= scan_entry_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      chk_ff         <= chk_in;
      byte_ff        <= byte_in;
      act_ff         <= act_in;
      emit_idx_ff    <= emit_idx_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // pending byte memory: written at the current position, read back on a miss
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_mem[pos_ff] <= key_char;
      end
      rd_q_ff <= pend_mem[emit_idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_payload_ff};
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_action_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("action item not marked last");

   a_action_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[6:0] < 7'd20))
      else $error("action code out of range");

   a_one_item_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(pos_ff) < CMP_W'(MAX_SEQ_LEN))
      else $error("match position past buffer");

endmodule

`default_nettype wire

@@ design/esm_seq_rom.sv @@
// esm_seq_rom: key sequence rom with a registered read port.
// depends on esm_pkg for the rom contents and word type.
`default_nettype none

module esm_seq_rom (
   input  wire logic                         clock,
   input  wire logic [esm_pkg::ENTRY_W-1:0]   entry,
   input  wire logic [esm_pkg::ROM_POS_W-1:0] pos,
   output esm_pkg::rom_word_type             rom_q
);

   esm_pkg::rom_word_type rom_q_ff;

   always_ff @(posedge clock) begin
      rom_q_ff <= esm_pkg::rom_lookup(entry, pos);
   end

   assign rom_q = rom_q_ff;

endmodule

`default_nettype wire
